### src/ple_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// shared constants and controller/datapath interface types for the
// positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  // default list capacity
  localparam int DEPTH_DEFAULT = 64;

  // field widths of the request and response words
  localparam int OPCODE_W   = 2;
  localparam int POSITION_W = 7;
  localparam int VALUE_W    = 32;
  localparam int LENGTH_W   = 7;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_GET    = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the request word
    logic start_ins;  // set up the move-back pass of an insert
    logic start_rem;  // set up the move-forward pass of a remove
    logic read_pos;   // read the entry at the request position
    logic step;       // move one entry
    logic put;        // write the new value at the request position
    logic commit;     // update the count and load the response word
  } ple_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic err;        // bad position or list full
    logic op_ins;
    logic op_rem;
    logic op_get;
    logic moves_zero; // no entries left to move
  } ple_status_t;

endpackage
`default_nettype wire

### src/ple_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_datapath
// entry memory, move pointers, entry count and response register
// ----------------------------------------------------------------------------
module ple_datapath #(
  parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic        [ple_pkg::OPCODE_W-1:0]   opcode,
  input  wire logic        [ple_pkg::POSITION_W-1:0] position,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]    value_in,
  input  wire ple_pkg::ple_cmd_t                     cmd,
  output ple_pkg::ple_status_t                       st,
  output logic                                       status,
  output logic signed      [ple_pkg::VALUE_W-1:0]    value_out,
  output logic             [ple_pkg::LENGTH_W-1:0]   length
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > ple_pkg::POSITION_W) ? CW : ple_pkg::POSITION_W;

  logic [ple_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [ple_pkg::OPCODE_W-1:0]   op_r;
  logic [ple_pkg::POSITION_W-1:0] pos_r;
  logic [ple_pkg::VALUE_W-1:0]    val_r;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;
  logic [CW-1:0]                  moves;
  logic [AW-1:0]                  rd_ptr;
  logic [AW-1:0]                  raddr;
  logic [AW-1:0]                  pend_addr;
  logic                           pend_valid;
  logic [ple_pkg::VALUE_W-1:0]    rdata;
  logic [CMPW-1:0]                pos_x;
  logic [CMPW-1:0]                count_x;
  logic [CMPW-1:0]                cnx;
  logic                           err;

  assign pos_x   = CMPW'(pos_r);
  assign count_x = CMPW'(count);

  always_comb begin
    case (op_r)
      ple_pkg::OP_INSERT: err = (pos_x > count_x) || (count_x >= CMPW'(DEPTH));
      ple_pkg::OP_REMOVE: err = pos_x >= count_x;
      ple_pkg::OP_GET:    err = pos_x >= count_x;
      default:            err = 1'b0;
    endcase
  end

  assign st.err        = err;
  assign st.op_ins     = (op_r == ple_pkg::OP_INSERT);
  assign st.op_rem     = (op_r == ple_pkg::OP_REMOVE);
  assign st.op_get     = (op_r == ple_pkg::OP_GET);
  assign st.moves_zero = (moves == '0);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      pos_r <= position;
      val_r <= value_in;
    end
  end

  // move pointers: insert walks down from the tail, remove walks up
  always_ff @(posedge clk) begin
    if (cmd.start_ins) begin
      moves  <= CW'(count_x - pos_x);
      rd_ptr <= AW'(count_x - CMPW'(1));
    end else if (cmd.start_rem) begin
      moves  <= CW'(count_x - pos_x - CMPW'(1));
      rd_ptr <= AW'(pos_x + CMPW'(1));
    end else if (cmd.step) begin
      moves  <= moves - CW'(1);
      rd_ptr <= st.op_ins ? rd_ptr - AW'(1) : rd_ptr + AW'(1);
    end
  end

  // each read is followed by its pending write in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pend_addr <= st.op_ins ? rd_ptr + AW'(1) : rd_ptr - AW'(1);
    end
  end

  assign raddr = cmd.step ? rd_ptr : AW'(pos_x);

  always_ff @(posedge clk) begin
    if (cmd.step || cmd.read_pos) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid) begin
      mem[pend_addr] <= rdata;
    end else if (cmd.put) begin
      mem[AW'(pos_x)] <= val_r;
    end
  end

  // count update and response word
  always_comb begin
    count_next = count;
    if (st.op_ins && !err) begin
      count_next = count + CW'(1);
    end else if (st.op_rem && !err) begin
      count_next = count - CW'(1);
    end else if (op_r == ple_pkg::OP_CLEAR) begin
      count_next = '0;
    end
  end

  assign cnx = CMPW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status    <= err;
      value_out <= (st.op_get && !err) ? rdata : '0;
      length    <= cnx[ple_pkg::LENGTH_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= CMPW'(DEPTH))
    else $error("entry count above capacity");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !cmd.put)
    else $error("shift write collides with insert write");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && st.op_ins && !err) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

endmodule
`default_nettype wire

### src/ple_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ple_controller
// operation sequencer and response valid flag
// ----------------------------------------------------------------------------
module ple_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  input  wire ple_pkg::ple_status_t st,
  output ple_pkg::ple_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.err) begin
          state_next = S_FINISH;
        end else if (st.op_ins) begin
          cmd.start_ins = 1'b1;
          state_next    = S_SHIFT;
        end else if (st.op_rem) begin
          cmd.start_rem = 1'b1;
          state_next    = S_SHIFT;
        end else if (st.op_get) begin
          cmd.read_pos = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        // the cycle after the last read drains the trailing write
        if (!st.moves_zero) begin
          cmd.step = 1'b1;
        end else if (st.op_ins) begin
          state_next = S_PUT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_DECODE))
    else $error("accepted word not decoded");

  a_err_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE && st.err) |=> (state == S_FINISH))
    else $error("rejected operation did not go straight to finish");

  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !rsp_valid) |=> (rsp_valid && state == S_IDLE))
    else $error("result not loaded into a free response slot");

  a_put_after_shift: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> ($past(state) == S_SHIFT))
    else $error("insert write without a finished shift");

endmodule
`default_nettype wire

### src/positional_list_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of up to DEPTH signed 32-bit entries with positional insert,
// remove, get and clear; one response word per request word
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------
//   req       req_valid / req_stall  opcode, position, value_in
//   rsp       rsp_valid / rsp_stall  status, value_out, length
//
// get, clear and rejected words go from accept through decode to the
//   finish state and the response register; insert adds a shift pass and
//   the insert write, remove a shift pass alone; the shift pass moves one
//   entry per cycle through the single write port of the entry memory
// one word is worked at a time; the next word is accepted while a response
//   still waits in the output register
// reset: synchronous, clears the entry count, sequencer and response valid;
//   entry memory is not cleared, only entries below the count are read
// stalls: a stalled response holds its word; a finished word waits in the
//   sequencer until the response register frees up
//
module positional_list_engine #(
  parameter int DEPTH = ple_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // request channel
  input  wire logic                                 req_valid,
  output logic                                      req_stall,
  input  wire logic        [ple_pkg::OPCODE_W-1:0]   opcode,
  input  wire logic        [ple_pkg::POSITION_W-1:0] position,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]    value_in,
  // response channel
  output logic                                      rsp_valid,
  input  wire logic                                 rsp_stall,
  output logic                                      status,
  output logic signed      [ple_pkg::VALUE_W-1:0]    value_out,
  output logic             [ple_pkg::LENGTH_W-1:0]   length
);

  ple_pkg::ple_cmd_t    cmd;
  ple_pkg::ple_status_t st;

  // sequencer: decode, shift pass, insert write, response handoff
  ple_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // entry memory, pointers, count and response word
  ple_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .opcode    (opcode),
    .position  (position),
    .value_in  (value_in),
    .cmd       (cmd),
    .st        (st),
    .status    (status),
    .value_out (value_out),
    .length    (length)
  );

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for positional_list_engine: request words are driven
// through the valid/stall channel while a shadow list in the bench tracks
// every accepted word; each response word is checked field by field
// against the oldest predicted answer, under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIST_DEPTH     = ple_pkg::DEPTH_DEFAULT;
  localparam int OP_W           = ple_pkg::OPCODE_W;
  localparam int POS_W          = ple_pkg::POSITION_W;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving
  localparam int DRAIN_CYCLES   = 80;    // longest insert plus margin

  // response status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef logic signed [ple_pkg::VALUE_W-1:0] list_value_t;

  // one predicted response word
  typedef struct {
    logic                         err;
    list_value_t                  data;
    logic [ple_pkg::LENGTH_W-1:0] count;
  } list_answer_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block inputs, all known from time zero
  logic               req_valid = 1'b0;
  logic [OP_W-1:0]    opcode    = ple_pkg::OP_CLEAR;
  logic [POS_W-1:0]   position  = '0;
  list_value_t        value_in  = '0;
  logic               rsp_stall = 1'b0;

  // block outputs
  logic                         req_stall;
  logic                         rsp_valid;
  logic                         status;
  list_value_t                  value_out;
  logic [ple_pkg::LENGTH_W-1:0] length;

  positional_list_engine #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode   (opcode),
    .position (position),
    .value_in (value_in),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status   (status),
    .value_out(value_out),
    .length   (length)
  );

  // shadow copy of the list contents and count
  list_value_t  list_mem [LIST_DEPTH];
  int           list_count = 0;
  list_answer_t answers_due [$];

  // idle mix, in percent of cycles
  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;

  // hold-off request from the test side, served by the receiver process
  bit hold_start = 1'b0;
  int hold_left  = 0;

  // random stimulus steering: grow toward full or shrink toward empty
  bit growing = 1'b1;

  // bookkeeping
  int errors        = 0;
  int words_sent    = 0;
  int words_checked = 0;
  int rejects       = 0;
  int full_rejects  = 0;
  int idle_cycles   = 0;

  // apply one accepted request word to the shadow list and queue its answer
  function automatic void apply_list_op(input logic [OP_W-1:0] op,
                                        input logic [POS_W-1:0] pos,
                                        input list_value_t val);
    list_answer_t a;
    int p;
    int i;
    a.err  = ST_OK;
    a.data = '0;
    p = pos;
    case (op)
      ple_pkg::OP_INSERT: begin
        if (p > list_count || list_count >= LIST_DEPTH) begin
          a.err = ST_ERR;
          if (list_count >= LIST_DEPTH) full_rejects++;
        end else begin
          // later entries move back by one
          for (i = list_count; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_count++;
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (p >= list_count) begin
          a.err = ST_ERR;
        end else begin
          // later entries move forward by one
          for (i = p; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end
      end
      ple_pkg::OP_GET: begin
        if (p >= list_count) a.err = ST_ERR;
        else a.data = list_mem[p];
      end
      default: begin
        // clear always succeeds
        list_count = 0;
      end
    endcase
    if (a.err == ST_ERR) rejects++;
    a.count = list_count[ple_pkg::LENGTH_W-1:0];
    answers_due.push_back(a);
  endfunction

  // offer one request word and hold it until accepted; called just after a
  // rising edge, leaves valid high so back-to-back words need no gap
  task automatic send_word(input logic [OP_W-1:0] op,
                           input int pos,
                           input list_value_t val);
    // random sender gap, repeated while the draw falls under the idle percentage
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode    <= op;
    position  <= POS_W'(pos);
    value_in  <= val;
    // stall is read before the edge updates land, so this is the accept cycle
    do @(posedge clk); while (req_stall);
    apply_list_op(op, POS_W'(pos), val);
    words_sent++;
  endtask

  // sender pause until every predicted answer has been seen
  task automatic wait_drained();
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // pick a random request word: mostly in-range positions against the
  // current shadow count, some raw noise with positions from 0 to LIST_DEPTH
  function automatic void pick_list_word(output logic [OP_W-1:0] op,
                                         output int pos,
                                         output list_value_t val);
    int r;
    int ins_w;
    int rem_w;
    r   = $urandom_range(0, 99);
    val = $urandom;
    // steer the count so it sweeps between empty and full
    if (list_count == 0) growing = 1'b1;
    else if (list_count >= LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
    else if ($urandom_range(0, 99) == 0) growing = ~growing;
    ins_w = growing ? 55 : 20;
    rem_w = growing ? 15 : 50;
    if (r < 8) begin
      // noise: any opcode, any position from 0 to LIST_DEPTH
      op  = OP_W'($urandom_range(0, 3));
      pos = $urandom_range(0, LIST_DEPTH);
    end else if (r < 9) begin
      op  = ple_pkg::OP_CLEAR;
      pos = $urandom_range(0, LIST_DEPTH);
    end else begin
      r = $urandom_range(0, 99);
      if (list_count == 0 || r < ins_w) begin
        op = ple_pkg::OP_INSERT;
        case ($urandom_range(0, 5))
          0:       pos = 0;
          1:       pos = list_count;
          default: pos = $urandom_range(0, list_count);
        endcase
      end else begin
        op = (r < ins_w + rem_w) ? ple_pkg::OP_REMOVE : ple_pkg::OP_GET;
        case ($urandom_range(0, 5))
          0:       pos = 0;
          1:       pos = list_count - 1;
          default: pos = $urandom_range(0, list_count - 1);
        endcase
      end
    end
  endfunction

  // receiver: check each accepted response word, then pick next stall
  always @(posedge clk) begin : rsp_side
    list_answer_t a;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        words_checked++;
        if (answers_due.size() == 0) begin
          $display("%0t: response word with nothing predicted: status %0d value %0d length %0d",
                   $time, status, value_out, length);
          errors++;
        end else begin
          a = answers_due.pop_front();
          if (status !== a.err) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, a.err, status);
            errors++;
          end
          if (value_out !== a.data) begin
            $display("%0t: value_out mismatch: expected %0d actual %0d",
                     $time, a.data, value_out);
            errors++;
          end
          if (length !== a.count) begin
            $display("%0t: length mismatch: expected %0d actual %0d",
                     $time, a.count, length);
            errors++;
          end
        end
      end
      // long hold-off counted here, otherwise random stall
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // watchdog: no word moving on either channel for too long ends the run
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d answers still due", $time, answers_due.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // every opcode, value extremes and each position error case on a short list
  task automatic test_directed();
    send_word(ple_pkg::OP_CLEAR,  0, $urandom);           // clear of an empty list
    send_word(ple_pkg::OP_GET,    0, $urandom);           // get on empty
    send_word(ple_pkg::OP_REMOVE, 0, $urandom);           // remove on empty
    send_word(ple_pkg::OP_INSERT, 1, 32'sh1234_5678);     // insert past the end
    send_word(ple_pkg::OP_INSERT, 0, 32'sh7fff_ffff);
    send_word(ple_pkg::OP_INSERT, 0, 32'sh8000_0000);     // insert at the front
    send_word(ple_pkg::OP_INSERT, 2, -32'sd1);            // insert at the end
    send_word(ple_pkg::OP_INSERT, 4, 32'sd5);             // past the end again
    send_word(ple_pkg::OP_INSERT, 1, 32'sd0);             // insert in the middle
    send_word(ple_pkg::OP_INSERT, 3, 32'sh5555_5555);
    send_word(ple_pkg::OP_INSERT, 1, 32'shaaaa_aaaa);
    send_word(ple_pkg::OP_GET,    0, $urandom);
    send_word(ple_pkg::OP_GET,    5, $urandom);           // last entry
    send_word(ple_pkg::OP_GET,    6, $urandom);           // get at the count
    send_word(ple_pkg::OP_GET,    LIST_DEPTH, $urandom);  // position at the capacity
    send_word(ple_pkg::OP_REMOVE, 6, $urandom);           // remove at the count
    send_word(ple_pkg::OP_REMOVE, 0, $urandom);           // remove the front
    send_word(ple_pkg::OP_REMOVE, 4, $urandom);           // remove the back
    send_word(ple_pkg::OP_REMOVE, 1, $urandom);           // remove in the middle
    send_word(ple_pkg::OP_GET,    0, $urandom);
    send_word(ple_pkg::OP_GET,    2, $urandom);
    send_word(ple_pkg::OP_CLEAR,  LIST_DEPTH, $urandom);  // clear of a list with entries
    send_word(ple_pkg::OP_GET,    0, $urandom);
    send_word(ple_pkg::OP_REMOVE, LIST_DEPTH, $urandom);
  endtask

  // fill to capacity, poke the full-list checks, then empty it again
  task automatic test_full_list();
    send_word(ple_pkg::OP_CLEAR, 0, $urandom);
    while (list_count < LIST_DEPTH)
      send_word(ple_pkg::OP_INSERT, $urandom_range(0, list_count), $urandom);
    send_word(ple_pkg::OP_INSERT, 0, $urandom);                 // full, front
    send_word(ple_pkg::OP_INSERT, LIST_DEPTH, $urandom);        // full, position at count
    send_word(ple_pkg::OP_GET,    LIST_DEPTH - 1, $urandom);
    send_word(ple_pkg::OP_GET,    LIST_DEPTH, $urandom);
    send_word(ple_pkg::OP_REMOVE, LIST_DEPTH - 1, $urandom);
    send_word(ple_pkg::OP_INSERT, LIST_DEPTH - 1, $urandom);    // back to full at the end
    send_word(ple_pkg::OP_REMOVE, 0, $urandom);                 // longest move forward
    send_word(ple_pkg::OP_INSERT, 0, $urandom);                 // longest move back
    while (list_count > 0) begin
      if ($urandom_range(0, 3) == 0)
        send_word(ple_pkg::OP_GET, $urandom_range(0, list_count - 1), $urandom);
      send_word(ple_pkg::OP_REMOVE, $urandom_range(0, list_count - 1), $urandom);
    end
  endtask

  // random words under one idle mix
  task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
    logic [OP_W-1:0] op;
    int              pos;
    list_value_t     val;
    int k;
    sender_idle_pct = snd_pct;
    recv_idle_pct   = rcv_pct;
    for (k = 0; k < n; k++) begin
      pick_list_word(op, pos, val);
      send_word(op, pos, val);
    end
  endtask

  // receiver holds off while the sender keeps offering, so the block
  // backs up and stalls its request side; then the sender waits for all
  task automatic test_backpressure();
    logic [OP_W-1:0] op;
    int              pos;
    list_value_t     val;
    int k;
    sender_idle_pct = 0;
    hold_start      = 1'b1;
    for (k = 0; k < 24; k++) begin
      pick_list_word(op, pos, val);
      send_word(op, pos, val);
    end
    req_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_list();
    test_random(400, 17, 86);
    test_backpressure();
    test_random(400, 86, 17);
    test_random(400, 0, 0);

    // end of stimulus: let the last answers come in, then a quiet tail
    req_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d request words and %0d response words, %0d rejected",
             words_sent, words_checked, rejects);
    $display("  of which %0d inserts hit a full list, across three idle mixes and a hold-off",
             full_rejects);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
src/ple_pkg.sv
src/ple_datapath.sv
src/ple_controller.sv
src/positional_list_engine.sv
sim/tb_top.sv
